// File: src/bmss_pkg.sv
// Shared types and constants for the booster mode and stall supervisor.
// No dependencies; every other file of the block uses this package.
package bmss_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  localparam logic [1:0] REG_STALL_TIME   = 2'd0;
  localparam logic [1:0] REG_TORQUE_LIMIT = 2'd1;
  localparam logic [1:0] REG_SPEED_LIMIT  = 2'd2;
  localparam logic [1:0] REG_CLEAR_TICKS  = 2'd3;

  localparam logic [15:0] STALL_TIME_RST   = 16'd1000;
  localparam logic [15:0] TORQUE_LIMIT_RST = 16'd2500;
  localparam logic [15:0] SPEED_LIMIT_RST  = 16'd100;
  localparam logic [3:0]  CLEAR_TICKS_RST  = 4'd8;

  localparam logic [1:0] REQ_NONE     = 2'd0;
  localparam logic [1:0] REQ_HOMING   = 2'd1;
  localparam logic [1:0] REQ_ANTI_JAM = 2'd2;
  localparam logic [1:0] REQ_STALL    = 2'd3;

  typedef struct packed {
    logic               kind;
    logic               anti_jam_cmd;
    logic [15:0]        cmd_reset_count;
    logic [15:0]        cmd_shoot_reset_count;
    logic signed [15:0] trig_speed;
    logic signed [15:0] trig_torque;
    logic [31:0]        time_now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] request;
    logic       shoot_data_reset;
    logic       stall_timing;
  } out_item_t;

  typedef struct packed {
    logic [15:0] stall_time_ms;
    logic [15:0] stall_torque_limit;
    logic [15:0] stall_speed_limit;
    logic [3:0]  clear_ticks;
  } cfg_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic        tick;
    logic        jam_cmd;
    logic        stall;
    logic [15:0] home_cnt;
    logic [15:0] shoot_count;
    logic [31:0] now_ms;
  } cls_item_t;

endpackage

// File: src/bmss_if.sv
// Valid/ready channel interfaces for input and result beats.
// Depends on bmss_pkg for the payload types.
interface bmss_in_if;
  logic               valid;
  logic               ready;
  bmss_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bmss_out_if;
  logic                valid;
  logic                ready;
  bmss_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: src/booster_mode_and_stall_supervisor_top.sv
// Booster mode and stall supervisor, top level.
// Input beats enter on in_i, one result beat per input leaves on out_o; both are
// valid/ready channels (bmss_in_if, bmss_out_if). An APB-style port writes and reads
// the four configuration registers at byte addresses 0, 4, 8 and 12: stall time,
// torque limit, speed limit and clear ticks. pready is always high.
// A beat is a control tick or an enter event. The front stage registers the beat and
// its stall condition, a two-entry queue decouples it from the back stage, which
// resolves the request, updates the held counters and the stall timer, and registers
// the result.
// Throughput: one beat per cycle while out_o does not stall, set by the state update
// in the back stage. Each result passes the front, queue and back stage registers.
// Reset clears all held state and loads the register defaults; no result is pending.
// When the receiver stalls, the result register holds, the queue fills, and in_i.ready
// drops once the front stage and the queue are full.
// Depends on bmss_pkg, bmss_if, bmss_front, bmss_queue and bmss_back.
module booster_mode_and_stall_supervisor_top #(
  parameter int CountWidth = bmss_pkg::COUNT_WIDTH,
  parameter int QueueDepth = bmss_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bmss_in_if.sink                         in_i,
  bmss_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bmss_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bmss_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bmss_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import bmss_pkg::*;

  cfg_t      cfg_q;
  logic [1:0] reg_idx;
  logic      cfg_wr;
  logic      fq_valid;
  cls_item_t fq_item;
  logic      fq_ready;
  logic      qb_valid;
  cls_item_t qb_item;
  logic      qb_ready;

  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stall_time_ms      <= STALL_TIME_RST;
      cfg_q.stall_torque_limit <= TORQUE_LIMIT_RST;
      cfg_q.stall_speed_limit  <= SPEED_LIMIT_RST;
      cfg_q.clear_ticks        <= CLEAR_TICKS_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_STALL_TIME:   cfg_q.stall_time_ms      <= pwdata[15:0];
        REG_TORQUE_LIMIT: cfg_q.stall_torque_limit <= pwdata[15:0];
        REG_SPEED_LIMIT:  cfg_q.stall_speed_limit  <= pwdata[15:0];
        REG_CLEAR_TICKS:  cfg_q.clear_ticks        <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_STALL_TIME:   prdata = {16'd0, cfg_q.stall_time_ms};
      REG_TORQUE_LIMIT: prdata = {16'd0, cfg_q.stall_torque_limit};
      REG_SPEED_LIMIT:  prdata = {16'd0, cfg_q.stall_speed_limit};
      REG_CLEAR_TICKS:  prdata = {28'd0, cfg_q.clear_ticks};
      default:          prdata = '0;
    endcase
  end

  bmss_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_i.valid),
    .in_item_i  (in_i.payload),
    .in_ready_o (in_i.ready),
    .q_valid_o  (fq_valid),
    .q_item_o   (fq_item),
    .q_ready_i  (fq_ready)
  );

  bmss_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_item_i  (fq_item),
    .wr_ready_o (fq_ready),
    .rd_valid_o (qb_valid),
    .rd_item_o  (qb_item),
    .rd_ready_i (qb_ready)
  );

  bmss_back #(
    .CountWidth (CountWidth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (qb_valid),
    .q_item_i    (qb_item),
    .q_ready_o   (qb_ready),
    .out_valid_o (out_o.valid),
    .out_item_o  (out_o.payload),
    .out_ready_i (out_o.ready)
  );

  a_stall_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.payload.request == REQ_STALL) |-> !out_o.payload.stall_timing)
    else $error("stall request left the timer armed");

  a_no_pulse_on_early_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && ((out_o.payload.request == REQ_HOMING) ||
                    (out_o.payload.request == REQ_ANTI_JAM))
    |-> !out_o.payload.shoot_data_reset)
    else $error("shoot data reset pulsed alongside homing or anti-jam request");

  a_queue_feeds_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qb_valid && qb_ready |=> out_o.valid)
    else $error("item taken by back stage produced no result");

endmodule

// File: src/bmss_front.sv
// Front stage: accepts input beats, classifies them and computes the stall condition.
// Depends on bmss_pkg.
module bmss_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bmss_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  input  bmss_pkg::in_item_t  in_item_i,
  output logic                in_ready_o,
  output logic                q_valid_o,
  output bmss_pkg::cls_item_t q_item_o,
  input  logic                q_ready_i
);
  import bmss_pkg::*;

  logic        valid_q;
  cls_item_t   item_q;
  cls_item_t   item_d;
  logic [16:0] speed_mag;
  logic [16:0] torque_mag;

  always_comb begin
    speed_mag  = in_item_i.trig_speed[15] ?
                 17'(17'h10000 - {1'b0, in_item_i.trig_speed}) : {1'b0, in_item_i.trig_speed};
    torque_mag = in_item_i.trig_torque[15] ?
                 17'(17'h10000 - {1'b0, in_item_i.trig_torque}) : {1'b0, in_item_i.trig_torque};
    item_d.tick        = in_item_i.kind;
    item_d.jam_cmd     = in_item_i.anti_jam_cmd;
    item_d.stall       = (speed_mag < {1'b0, cfg_i.stall_speed_limit}) &&
                         (torque_mag > {1'b0, cfg_i.stall_torque_limit});
    item_d.home_cnt    = in_item_i.cmd_reset_count;
    item_d.shoot_count = in_item_i.cmd_shoot_reset_count;
    item_d.now_ms      = in_item_i.time_now_ms;
  end

  assign in_ready_o = !valid_q || q_ready_i;
  assign q_valid_o  = valid_q;
  assign q_item_o   = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

// File: src/bmss_queue.sv
// Short queue of classified items between the front and back stages.
// Depends on bmss_pkg.
module bmss_queue #(
  parameter int Depth = bmss_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  input  bmss_pkg::cls_item_t wr_item_i,
  output logic                wr_ready_o,
  output logic                rd_valid_o,
  output bmss_pkg::cls_item_t rd_item_o,
  input  logic                rd_ready_i
);
  import bmss_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cls_item_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q;
  logic [PtrW-1:0]     rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                push;
  logic                pop;

  assign wr_ready_o = (cnt_q != CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
      end
      if (push && !pop) begin
        cnt_q <= CntW'(cnt_q + 1'b1);
      end else if (pop && !push) begin
        cnt_q <= CntW'(cnt_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

// File: src/bmss_back.sv
// Back stage: resolves sub-state requests, runs the stall timer, registers results.
// Depends on bmss_pkg.
module bmss_back #(
  parameter int CountWidth = bmss_pkg::COUNT_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bmss_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  input  bmss_pkg::cls_item_t q_item_i,
  output logic                q_ready_o,
  output logic                out_valid_o,
  output bmss_pkg::out_item_t out_item_o,
  input  logic                out_ready_i
);
  import bmss_pkg::*;

  localparam int HeldW = (CountWidth < 16) ? CountWidth : 16;

  logic [HeldW-1:0] held_rc_q, held_rc_d;
  logic [HeldW-1:0] held_sc_q, held_sc_d;
  logic             anti_q, anti_d;
  logic             armed_q, armed_d;
  logic [31:0]      start_q, start_d;
  logic [3:0]       clr_q, clr_d;
  logic [3:0]       clr_inc;
  logic [31:0]      elapsed;
  logic [HeldW-1:0] rc;
  logic [HeldW-1:0] sc;
  logic             out_valid_q;
  out_item_t        out_q, out_d;
  logic             take;

  assign rc        = q_item_i.home_cnt[HeldW-1:0];
  assign sc        = q_item_i.shoot_count[HeldW-1:0];
  assign elapsed   = q_item_i.now_ms - start_q;
  assign clr_inc   = clr_q + 4'd1;
  assign q_ready_o = !out_valid_q || out_ready_i;
  assign take      = q_valid_i && q_ready_o;

  always_comb begin
    held_rc_d = held_rc_q;
    held_sc_d = held_sc_q;
    anti_d    = anti_q;
    armed_d   = armed_q;
    start_d   = start_q;
    clr_d     = clr_q;
    out_d.request          = REQ_NONE;
    out_d.shoot_data_reset = 1'b0;
    if (!q_item_i.tick) begin
      held_rc_d     = rc;
      held_sc_d     = sc;
      anti_d        = 1'b0;
      out_d.request = REQ_HOMING;
    end else if (q_item_i.jam_cmd) begin
      if (!anti_q) begin
        anti_d        = 1'b1;
        out_d.request = REQ_ANTI_JAM;
      end
    end else if (anti_q) begin
      anti_d        = 1'b0;
      out_d.request = REQ_HOMING;
    end else if (rc != held_rc_q) begin
      held_rc_d     = rc;
      out_d.request = REQ_HOMING;
    end else begin
      if (sc != held_sc_q) begin
        held_sc_d              = sc;
        out_d.shoot_data_reset = 1'b1;
      end
      if (q_item_i.stall) begin
        clr_d = '0;
        if (!armed_q) begin
          armed_d = 1'b1;
          start_d = q_item_i.now_ms;
        end else if (elapsed >= {16'd0, cfg_i.stall_time_ms}) begin
          out_d.request = REQ_STALL;
          armed_d       = 1'b0;
          start_d       = '0;
        end
      end else if (armed_q) begin
        if (clr_inc >= cfg_i.clear_ticks) begin
          armed_d = 1'b0;
          start_d = '0;
          clr_d   = '0;
        end else begin
          clr_d = clr_inc;
        end
      end else begin
        clr_d = '0;
      end
    end
    out_d.stall_timing = armed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_rc_q   <= '0;
      held_sc_q   <= '0;
      anti_q      <= 1'b0;
      armed_q     <= 1'b0;
      start_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (take) begin
        held_rc_q <= held_rc_d;
        held_sc_q <= held_sc_d;
        anti_q    <= anti_d;
        armed_q   <= armed_d;
        start_q   <= start_d;
        clr_q     <= clr_d;
        out_q     <= out_d;
      end
      if (q_ready_o) begin
        out_valid_q <= q_valid_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
